// ----- hw/rtl/hcbp_pkg.sv -----
// ---------------------------------------------------------------------------
// hcbp_pkg
// Shared constants for the code bit packer: table geometry, code widths,
// group size and operation codes.
// ---------------------------------------------------------------------------
package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int MAX_CODE_LEN = 32;
    localparam int WORD_BITS    = 32;
    localparam int LEN_CAP      = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int LEN_W        = 6;
    localparam int SHAMT_W      = $clog2(WORD_BITS) + 1;
    localparam int GROUP_BITS   = 7;
    localparam int USED_W       = 3;
    localparam int ENTRY_W      = LEN_W + WORD_BITS;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [7:0] FINAL_MARK = 8'h80;

endpackage

// ----- hw/rtl/hcbp_ram.sv -----
// ---------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/hcbp_shift.sv -----
// ---------------------------------------------------------------------------
// hcbp_shift
// Shared left barrel shifter: aligns a code word to the top and consumes
// the bits that each packing step has placed.
// ---------------------------------------------------------------------------
module hcbp_shift (
    input  logic [hcbp_pkg::WORD_BITS-1:0] din,
    input  logic [hcbp_pkg::SHAMT_W-1:0]   amt,
    output logic [hcbp_pkg::WORD_BITS-1:0] dout
);

    import hcbp_pkg::*;

    always_comb
    begin
        if (amt >= SHAMT_W'(WORD_BITS))
        begin
            dout = '0;
        end
        else
        begin
            dout = din << amt;
        end
    end

endmodule

// ----- hw/rtl/huffman_code_bit_packer.sv -----
// ---------------------------------------------------------------------------
// huffman_code_bit_packer
// Variable-length code packer: loads a code table, packs code bits into
// 7-bit groups sent as bytes, and closes a stream with a marked group and
// its bit count.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_ready  | op, symbol, code_bits, code_len
//   out     | output    | out_valid / out_ready| code_byte, last
//
// Load and unused op complete in idle; finish passes FIN1 and FIN2 and waits
// on output stalls. Encode does one table read, one alignment pass through
// the shifter, k packing steps of up to seven bits each, e byte sends (0..5).
// in_ready is high only when the sequencer is idle; out stalls hold the
// sequencer at its next byte send. Reset clears group and count; the table
// holds unknown data until loaded.
// ---------------------------------------------------------------------------
module huffman_code_bit_packer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           op,
    input  logic [7:0]                           symbol,
    input  logic [hcbp_pkg::WORD_BITS-1:0]       code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]           code_len,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [7:0]                           code_byte,
    output logic                                 last
);

    import hcbp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_PACK = 3'd2;
    localparam logic [2:0] ST_FIN1 = 3'd3;
    localparam logic [2:0] ST_FIN2 = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [GROUP_BITS-1:0] pending_reg, pending_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [WORD_BITS-1:0]  aligned_reg, aligned_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            code_byte_reg, code_byte_next;
    logic                  last_reg, last_next;

    logic                  in_fire;
    logic                  sym_ok;
    logic                  out_free;
    logic [LEN_W-1:0]      len_sat;
    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [WORD_BITS-1:0]  rd_code;
    logic [LEN_W-1:0]      rd_len;
    logic [WORD_BITS-1:0]  sh_in;
    logic [SHAMT_W-1:0]    sh_amt;
    logic [WORD_BITS-1:0]  sh_out;
    logic [USED_W-1:0]     space;
    logic [USED_W-1:0]     step_n;
    logic [GROUP_BITS-1:0] top_bits;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign sym_ok    = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    assign out_free  = !out_valid_reg || out_ready;
    assign len_sat   = (code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_len;
    assign ram_we    = in_fire && (op == OP_LOAD) && sym_ok;
    assign rd_code   = ram_rdata[WORD_BITS-1:0];
    assign rd_len    = ram_rdata[ENTRY_W-1:WORD_BITS];

    assign out_valid = out_valid_reg;
    assign code_byte = code_byte_reg;
    assign last      = last_reg;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (symbol[SYM_AW-1:0]),
        .wdata ({len_sat, code_bits}),
        .raddr (symbol[SYM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign space    = USED_W'(GROUP_BITS) - used_reg;
    assign step_n   = (rem_reg < {3'b0, space}) ? rem_reg[USED_W-1:0] : space;
    assign top_bits = aligned_reg[WORD_BITS-1 -: GROUP_BITS];

    always_comb
    begin
        if (state_reg == ST_READ)
        begin
            sh_in  = rd_code;
            sh_amt = SHAMT_W'(WORD_BITS) - SHAMT_W'(rd_len);
        end
        else
        begin
            sh_in  = aligned_reg;
            sh_amt = SHAMT_W'(step_n);
        end
    end

    hcbp_shift u_shift (
        .din  (sh_in),
        .amt  (sh_amt),
        .dout (sh_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        used_next      = used_reg;
        rem_next       = rem_reg;
        aligned_next   = aligned_reg;
        out_valid_next = out_valid_reg && !out_ready;
        code_byte_next = code_byte_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        OP_ENCODE:
                        begin
                            if (sym_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        OP_FINISH:
                        begin
                            state_next = ST_FIN1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                aligned_next = sh_out;
                rem_next     = rd_len;
                state_next   = (rd_len == '0) ? ST_IDLE : ST_PACK;
            end
            ST_PACK:
            begin
                if (used_reg == USED_W'(GROUP_BITS))
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        code_byte_next = {1'b0, pending_reg};
                        last_next      = (rem_reg <= LEN_W'(GROUP_BITS));
                        pending_next   = '0;
                        used_next      = '0;
                    end
                end
                else
                begin
                    pending_next = pending_reg | (top_bits >> used_reg);
                    aligned_next = sh_out;
                    used_next    = used_reg + step_n;
                    rem_next     = rem_reg - LEN_W'(step_n);
                    if (rem_reg == LEN_W'(step_n))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_byte_next = FINAL_MARK | {1'b0, pending_reg};
                    last_next      = 1'b0;
                    state_next     = ST_FIN2;
                end
            end
            ST_FIN2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    code_byte_next = {5'b0, used_reg};
                    last_next      = 1'b1;
                    pending_next   = '0;
                    used_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= '0;
            used_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            used_reg      <= used_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        aligned_reg   <= aligned_next;
        code_byte_reg <= code_byte_next;
        last_reg      <= last_next;
    end

`ifndef SYNTH
    a_pack_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PACK) |-> (rem_reg != '0))
        else $error("packing step with no bits left");

    a_group_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((pending_reg & (7'h7f >> used_reg)) == '0))
        else $error("pending group has bits below the fill point");

    a_rem_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg <= LEN_W'(LEN_CAP)))
        else $error("remaining bit count beyond code length cap");

    a_finish_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op == OP_FINISH)) |=> (state_reg == ST_FIN1))
        else $error("finish did not start its byte sequence");
`endif

endmodule

// ----- dv/hcbp_stream_checker.sv -----
// ---------------------------------------------------------------------------
// hcbp_stream_checker
// Watches both channels of the code bit packer. Each accepted input word
// updates a private copy of the code table and the pending group, and queues
// the bytes that word must produce. Each accepted output word is compared
// with the oldest queued byte. Failures and the number of bytes still owed
// are handed to the testbench top.
// ---------------------------------------------------------------------------
module hcbp_stream_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [7:0]                     symbol,
    input  logic [hcbp_pkg::WORD_BITS-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]     code_len,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [7:0]                     code_byte,
    input  logic                           last,
    output int                             fail_count,
    output int                             owed_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import hcbp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       tail;
    } packed_byte_t;

    logic [WORD_BITS-1:0]  code_tbl [SYMBOL_COUNT];
    logic [LEN_W-1:0]      len_tbl  [SYMBOL_COUNT];
    logic [GROUP_BITS-1:0] group_acc;
    logic [USED_W-1:0]     group_fill;
    packed_byte_t          packed_q [$];
    int                    fails;

    initial
    begin
        group_acc  = '0;
        group_fill = '0;
        fails      = 0;
    end

    task automatic pack_item(input logic [1:0] w_op, input logic [7:0] w_sym,
                             input logic [WORD_BITS-1:0] w_bits,
                             input logic [LEN_W-1:0] w_len);
        int           i;
        int           sent;
        int           n;
        logic [WORD_BITS-1:0] code;
        packed_byte_t pb;
        sent = 0;
        if (w_op == OP_LOAD)
        begin
            if (int'(w_sym) < SYMBOL_COUNT)
            begin
                code_tbl[w_sym] = w_bits;
                len_tbl[w_sym]  = (int'(w_len) > LEN_CAP) ? LEN_W'(LEN_CAP) : w_len;
            end
        end
        else if (w_op == OP_ENCODE)
        begin
            if (int'(w_sym) < SYMBOL_COUNT)
            begin
                code = code_tbl[w_sym];
                n    = int'(len_tbl[w_sym]);
                if (n > WORD_BITS)
                    n = WORD_BITS;
                for (i = n; i > 0; i--)
                begin
                    if (int'(group_fill) >= GROUP_BITS)
                    begin
                        pb.data = {1'b0, group_acc};
                        pb.tail = 1'b0;
                        packed_q.push_back(pb);
                        sent++;
                        group_acc  = '0;
                        group_fill = '0;
                    end
                    if (code[i-1])
                        group_acc[6 - group_fill] = 1'b1;
                    group_fill++;
                end
                if (sent > 0)
                    packed_q[packed_q.size()-1].tail = 1'b1;
            end
        end
        else if (w_op == OP_FINISH)
        begin
            pb.data = {1'b0, group_acc} | FINAL_MARK;
            pb.tail = 1'b0;
            packed_q.push_back(pb);
            pb.data = {5'd0, group_fill};
            pb.tail = 1'b1;
            packed_q.push_back(pb);
            group_acc  = '0;
            group_fill = '0;
        end
    endtask

    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pack_item(op, symbol, code_bits, code_len);
            if (out_valid && out_ready)
            begin
                if (packed_q.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: unexpected out word byte %h last %b",
                                 $realtime, code_byte, last);
                    fails++;
                end
                else
                begin
                    want = packed_q.pop_front();
                    if (code_byte !== want.data || last !== want.tail)
                    begin
                        if (fails < 10)
                            $display("%0t: out word byte %h last %b, expected byte %h last %b",
                                     $realtime, code_byte, last, want.data, want.tail);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        owed_count <= packed_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the code bit packer. A directed run covers empty
// and saturated code lengths, full groups, finishes with no and seven bits
// pending and the unused op; then a random stream of table loads, encodes of
// loaded symbols, finishes and unused ops, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hcbp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 300;
    localparam int DRAIN_CYCLES = 40;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [1:0]           op        = OP_LOAD;
    logic [7:0]           symbol    = '0;
    logic [WORD_BITS-1:0] code_bits = '0;
    logic [LEN_W-1:0]     code_len  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           code_byte;
    logic                 last;
    int                   fail_count;
    int                   owed_count;

    bit                   loaded [SYMBOL_COUNT];
    int                   loaded_syms [$];
    int                   send_calm  = 0;
    int                   ready_calm = 0;
    int                   stall_left = 0;

    huffman_code_bit_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .symbol    (symbol),
        .code_bits (code_bits),
        .code_len  (code_len),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_byte (code_byte),
        .last      (last)
    );

    hcbp_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .symbol     (symbol),
        .code_bits  (code_bits),
        .code_len   (code_len),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_byte  (code_byte),
        .last       (last),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("huffman_code_bit_packer: mismatch");
        $finish;
    end

    function automatic int idle_len(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = idle_len(ready_calm);
        end
    end

    task automatic send_word(input logic [1:0] w_op, input logic [7:0] w_sym,
                             input logic [WORD_BITS-1:0] w_bits,
                             input logic [LEN_W-1:0] w_len);
        int gap;
        in_valid  <= 1'b1;
        op        <= w_op;
        symbol    <= w_sym;
        code_bits <= w_bits;
        code_len  <= w_len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (w_op == OP_LOAD && !loaded[w_sym])
        begin
            loaded[w_sym] = 1'b1;
            loaded_syms.push_back(int'(w_sym));
        end
        gap = idle_len(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_owed();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int               r;
        logic [7:0]       sym;
        logic [LEN_W-1:0] len;
        r   = $urandom_range(0, 99);
        sym = 8'($urandom_range(0, 255));
        if (r < 4)
        begin
            send_word(OP_UNUSED, sym, $urandom, LEN_W'($urandom));
        end
        else if (r < 25 || loaded_syms.size() == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                len = '0;
            else if (r < 80)
                len = LEN_W'($urandom_range(1, 9));
            else if (r < 94)
                len = LEN_W'($urandom_range(10, 32));
            else
                len = LEN_W'($urandom_range(33, 63));
            if ($urandom_range(0, 3) != 0 && loaded_syms.size() > 0)
                sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            send_word(OP_LOAD, sym, $urandom, len);
        end
        else if (r < 88)
        begin
            sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            send_word(OP_ENCODE, sym, $urandom, LEN_W'($urandom));
        end
        else
        begin
            send_word(OP_FINISH, sym, $urandom, LEN_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_FINISH,  8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_LOAD,    8'd0,   32'hFFFF_FFFF, 6'd0);
        send_word(OP_LOAD,    8'd255, 32'hFFFF_FFFF, 6'd32);
        send_word(OP_LOAD,    8'd1,   32'hA5A5_A5A5, 6'd63);
        send_word(OP_LOAD,    8'd2,   32'h0000_005A, 6'd7);
        send_word(OP_LOAD,    8'd3,   32'h0000_0000, 6'd1);
        send_word(OP_LOAD,    8'd4,   32'h0000_0001, 6'd1);
        send_word(OP_LOAD,    8'd5,   32'h8000_0001, 6'd33);
        send_word(OP_ENCODE,  8'd0,   32'hFFFF_FFFF, 6'd63);
        send_word(OP_ENCODE,  8'd2,   32'h0000_0000, 6'd0);
        send_word(OP_FINISH,  8'd255, 32'hFFFF_FFFF, 6'd63);
        send_word(OP_ENCODE,  8'd2,   32'h0000_0000, 6'd0);
        send_word(OP_ENCODE,  8'd4,   32'h0000_0000, 6'd0);
        send_word(OP_ENCODE,  8'd255, 32'h0000_0000, 6'd0);
        send_word(OP_ENCODE,  8'd1,   32'h0000_0000, 6'd0);
        send_word(OP_UNUSED,  8'd255, 32'hFFFF_FFFF, 6'd63);
        send_word(OP_ENCODE,  8'd5,   32'h0000_0000, 6'd0);
        send_word(OP_FINISH,  8'd0,   32'h0000_0000, 6'd0);
        send_word(OP_ENCODE,  8'd3,   32'h0000_0000, 6'd0);
        send_word(OP_ENCODE,  8'd255, 32'h0000_0000, 6'd0);
        send_word(OP_FINISH,  8'd0,   32'h0000_0000, 6'd0);

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k == RANDOM_WORDS / 2)
                drain_owed();
            send_random();
        end

        drain_owed();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("huffman_code_bit_packer: match");
        else
            $display("huffman_code_bit_packer: mismatch");
        $finish;
    end

endmodule
